// ----- design/bitmap_line_drawer_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the line drawer
// ---------------------------------------------------------------------------
`ifndef BITMAP_LINE_DRAWER_MACROS_SVH
`define BITMAP_LINE_DRAWER_MACROS_SVH

// implication checked every clock outside reset
`define BLD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BLD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/bld_pkg.sv -----
// ---------------------------------------------------------------------------
// bld_pkg
// Shared types and constants for the bitmap line drawer.
// ---------------------------------------------------------------------------
`default_nettype none
package bld_pkg;
  localparam int ROWS      = 256;
  localparam int COLS      = 256;
  localparam int ROW_BYTES = (COLS + 7) / 8;
  localparam int DEPTH     = ROWS * ROW_BYTES;
  localparam int AW        = $clog2(DEPTH);
  localparam int DW        = 32;   // line numerator/denominator width
  localparam int QW        = 14;   // coordinate width less one

  typedef enum logic [1:0] {
    ACT_LINE = 2'd0,
    ACT_FILL = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT, S_SWEEP, S_PT, S_DIVW, S_RD, S_WR, S_RDB, S_RDB2,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MODE_COL,    // ends share a row: walk columns
    MODE_ROW,    // ends share a column: walk rows
    MODE_SLOPE   // tenth-row samples
  } walk_mode_t;

  // one memory access request from the sequencer
  typedef struct packed {
    logic          rd;   // read for read-modify-write or byte read
    logic          wr;   // write full byte
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// ----- design/bitmap_line_drawer.sv -----
// ---------------------------------------------------------------------------
// bitmap_line_drawer
// 1bpp bitmap with line draw, fill and byte read over one pixel store.
// ---------------------------------------------------------------------------
// Usage: one input transaction per command on in_*, one output transaction
// per command on out_* carrying read_byte (zero unless action is read).
// Commands run one at a time: in_tready is high only while the sequencer is
// idle and no command is in flight. A result waits in the output register
// while out_tready is low; the next command may be taken then, and its own
// result is held in the sequencer until the register frees up.
// A byte read passes through S_RDB and S_RDB2 to S_DONE; an unused code or
// a read outside the window goes straight to S_DONE; a fill writes all
// ROWS*ROW_BYTES bytes. Axis lines do a store read-modify-write per pixel
// inside the window and skip the store outside it. Sloped lines take one
// sample per tenth of a row, each through a 32-step serial divider, then
// the store read-modify-write, which is skipped when the point is outside.
// in_tready rises in the cycle that the result appears on out_tvalid.
// After reset a clearing pass over all ROWS*ROW_BYTES (8192) bytes zeroes
// the store; in_tready stays low until it ends.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitmap_line_drawer_macros.svh"
module bitmap_line_drawer
  import bld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [14:2] x_start, [27:15] y_start, [40:28] x_end,
  // [53:41] y_end, [54] pixel_value, [62:55] row_index, [67:63] byte_index
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] read_byte
  output logic [7:0]       out_tdata
);
  logic busy, done, hold;
  logic [7:0] result, rdata;
  mem_req_t req;
  logic ovalid_r, pend_r;

  assign in_tready = !busy && !pend_r;
  assign hold = ovalid_r && !out_tready;

  bld_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && in_tready),
    .action(in_tdata[1:0]), .xs(in_tdata[14:2]), .ys(in_tdata[27:15]),
    .xe(in_tdata[40:28]), .ye(in_tdata[53:41]), .val(in_tdata[54]),
    .row_i(in_tdata[62:55]), .grp_i(in_tdata[67:63]), .hold(hold),
    .busy(busy), .done(done), .result(result), .req(req), .rdata(rdata)
  );

  bld_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  // pend_r: a command is in flight (stalls intake until result is placed)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pend_r <= 1'b1;
      else if (done && !hold) pend_r <= 1'b0;
      if (done && !hold) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (done && !hold) out_tdata <= result;
  end
  assign out_tvalid = ovalid_r;

  `BLD_ASSERT_IMP(a_no_accept_busy, in_tvalid && in_tready, !busy)
  `BLD_ASSERT_NXT(a_pend_after_accept, in_tvalid && in_tready, pend_r)
  `BLD_ASSERT_IMP(a_mem_one_op, req.wr, !req.rd)
endmodule
`default_nettype wire

// ----- design/bld_ram.sv -----
// ---------------------------------------------------------------------------
// bld_ram
// Single-port synchronous pixel store with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module bld_ram
  import bld_pkg::*;
(
  input  wire logic          clk,
  input  wire mem_req_t      req,
  output logic [7:0]         rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.addr] <= req.wdata;
    if (req.rd) rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

// ----- design/bld_seq.sv -----
// ---------------------------------------------------------------------------
// bld_seq
// Sequencer: walks line points, fill and clear sweeps, byte reads, and does
// read-modify-write of the pixel store.
// ---------------------------------------------------------------------------
`default_nettype none
module bld_seq
  import bld_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    action,
  input  wire logic [12:0]   xs,
  input  wire logic [12:0]   ys,
  input  wire logic [12:0]   xe,
  input  wire logic [12:0]   ye,
  input  wire logic          val,
  input  wire logic [7:0]    row_i,
  input  wire logic [4:0]    grp_i,
  input  wire logic          hold,
  output logic               busy,
  output logic               done,
  output logic [7:0]         result,
  output mem_req_t           req,
  input  wire logic [7:0]    rdata
);
  seq_state_t st_r, st_nxt;
  logic [AW:0]  cnt_r, cnt_nxt;
  logic [7:0]   fillv_r, fillv_nxt;
  walk_mode_t   mode_r, mode_nxt;
  logic signed [QW+4:0] t_r, t_nxt, tend_r, tend_nxt;  // row walk / tenths
  logic signed [QW+4:0] row_r, row_nxt;                // floor(t / 10)
  logic [3:0]   frac_r, frac_nxt;                      // t mod 10
  logic signed [QW:0]   c_r, c_nxt;                    // fixed coordinate
  logic signed [DW-1:0] num_r, num_nxt, den_r, den_nxt, step_r, step_nxt;
  logic signed [QW+4:0] px_r, px_nxt, py_r, py_nxt;
  logic         val_r, val_nxt;
  logic [7:0]   res_r, res_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  // restoring divider of |num| by |den|
  logic [DW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dv_r, dv_nxt;
  logic [5:0]   dcnt_r, dcnt_nxt;
  logic         qneg_r, qneg_nxt;

  logic signed [QW:0] sxs, sys, sxe, sye, dx, dy;
  logic [DW:0]  trial;
  logic         inwin;
  logic signed [QW+4:0] row_inc;
  logic [3:0]   frac_inc;

  assign sxs = (QW+1)'(signed'(xs)); assign sys = (QW+1)'(signed'(ys));
  assign sxe = (QW+1)'(signed'(xe)); assign sye = (QW+1)'(signed'(ye));
  assign dx = sxe - sxs; assign dy = sye - sys;
  assign trial = {rem_r, quo_r[DW-1]} - {1'b0, dv_r};
  assign inwin = px_r >= 0 && px_r < ROWS && py_r >= 0 && py_r < COLS;
  assign row_inc  = (frac_r == 4'd9) ? row_r + (QW+5)'(1) : row_r;
  assign frac_inc = (frac_r == 4'd9) ? 4'd0 : frac_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; cnt_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
    end
    fillv_r <= fillv_nxt; mode_r <= mode_nxt; t_r <= t_nxt; tend_r <= tend_nxt;
    row_r <= row_nxt; frac_r <= frac_nxt;
    c_r <= c_nxt; num_r <= num_nxt; den_r <= den_nxt; step_r <= step_nxt;
    px_r <= px_nxt; py_r <= py_nxt; val_r <= val_nxt; res_r <= res_nxt;
    addr_r <= addr_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; dv_r <= dv_nxt;
    dcnt_r <= dcnt_nxt; qneg_r <= qneg_nxt;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; fillv_nxt = fillv_r; mode_nxt = mode_r;
    t_nxt = t_r; tend_nxt = tend_r; c_nxt = c_r; num_nxt = num_r;
    row_nxt = row_r; frac_nxt = frac_r;
    den_nxt = den_r; step_nxt = step_r; px_nxt = px_r; py_nxt = py_r;
    val_nxt = val_r; res_nxt = res_r; addr_nxt = addr_r; rem_nxt = rem_r;
    quo_nxt = quo_r; dv_nxt = dv_r; dcnt_nxt = dcnt_r; qneg_nxt = qneg_r;
    req = '0; busy = 1'b1; done = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        req.wr = 1'b1; req.addr = cnt_r[AW-1:0]; req.wdata = 8'h00;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          res_nxt = 8'h00; val_nxt = val;
          unique case (action_t'(action))
            ACT_LINE: begin
              st_nxt = S_PT;
              if (sxs == sxe) begin
                mode_nxt = MODE_COL; c_nxt = sxs;
                t_nxt = (sys < sye) ? (QW+5)'(sys) : (QW+5)'(sye);
                tend_nxt = (sys < sye) ? (QW+5)'(sye) : (QW+5)'(sys);
              end else if (sys == sye) begin
                mode_nxt = MODE_ROW; c_nxt = sys;
                t_nxt = (sxs < sxe) ? (QW+5)'(sxs) : (QW+5)'(sxe);
                tend_nxt = (sxs < sxe) ? (QW+5)'(sxe) : (QW+5)'(sxs);
              end else begin
                mode_nxt = MODE_SLOPE;
                row_nxt = (sxs < sxe) ? (QW+5)'(sxs) : (QW+5)'(sxe);
                frac_nxt = 4'd0;
                t_nxt = (QW+5)'(10 * ((sxs < sxe) ? sxs : sxe));
                tend_nxt = (QW+5)'(10 * ((sxs < sxe) ? sxe : sxs));
                den_nxt = 10 * DW'(dx);
                step_nxt = DW'(dy);
                // num at the first sample row is den times that end's column
                c_nxt = (sxs < sxe) ? sys : sye;
                st_nxt = S_INIT;
              end
            end
            ACT_FILL: begin
              fillv_nxt = {8{val}}; cnt_nxt = '0; st_nxt = S_SWEEP;
            end
            ACT_READ: begin
              if (32'(row_i) < ROWS && 32'(grp_i) < COLS / 8) begin
                addr_nxt = AW'(32'(row_i) * ROW_BYTES + 32'(grp_i));
                st_nxt = S_RDB;
              end else st_nxt = S_DONE;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        num_nxt = den_r * DW'(c_r); st_nxt = S_PT;
      end
      S_SWEEP: begin
        req.wr = 1'b1; req.addr = cnt_r[AW-1:0]; req.wdata = fillv_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH - 1)) st_nxt = S_DONE;
      end
      S_PT: begin
        if (t_r > tend_r) st_nxt = S_DONE;
        else if (mode_r == MODE_COL) begin
          px_nxt = (QW+5)'(c_r); py_nxt = t_r; st_nxt = S_RD;
        end else if (mode_r == MODE_ROW) begin
          px_nxt = t_r; py_nxt = (QW+5)'(c_r); st_nxt = S_RD;
        end else begin
          // truncate toward zero: negative rows with a fraction round up
          px_nxt = (row_r < 0 && frac_r != 4'd0) ? row_r + (QW+5)'(1) : row_r;
          qneg_nxt = num_r[DW-1] ^ den_r[DW-1];
          rem_nxt = '0;
          quo_nxt = num_r[DW-1] ? DW'(-num_r) : num_r;
          dv_nxt = den_r[DW-1] ? DW'(-den_r) : den_r;
          dcnt_nxt = '0; st_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (!trial[DW]) begin
          rem_nxt = trial[DW-1:0]; quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DW-2:0], quo_r[DW-1]}; quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'(DW - 1)) begin
          py_nxt = qneg_r ? (QW+5)'(-signed'(quo_nxt)) : (QW+5)'(quo_nxt);
          st_nxt = S_RD;
        end
      end
      S_RD: begin
        if (inwin) begin
          addr_nxt = AW'(32'(px_r) * ROW_BYTES + 32'(py_r >>> 3));
          req.rd = 1'b1; req.addr = addr_nxt;
          st_nxt = S_WR;
        end else begin
          t_nxt = t_r + (QW+5)'(1); row_nxt = row_inc; frac_nxt = frac_inc;
          num_nxt = num_r + step_r; st_nxt = S_PT;
        end
      end
      S_WR: begin
        req.wr = 1'b1; req.addr = addr_r;
        req.wdata = rdata;
        req.wdata[py_r[2:0]] = val_r;
        t_nxt = t_r + (QW+5)'(1); row_nxt = row_inc; frac_nxt = frac_inc;
        num_nxt = num_r + step_r; st_nxt = S_PT;
      end
      S_RDB: begin
        req.rd = 1'b1; req.addr = addr_r; st_nxt = S_RDB2;
      end
      S_RDB2: begin
        res_nxt = rdata; st_nxt = S_DONE;
      end
      S_DONE: begin
        // wait here while the output register is still occupied
        done = 1'b1;
        if (!hold) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
  assign result = res_r;
endmodule
`default_nettype wire
